/* design/trbr_pkg.sv */
// ----------------------------------------------------------------------------
// trbr_pkg: shared types and constants of the triangle rasterizer
// Item kind codes, vertex slot numbering, color width and default coordinate
// width used by the interfaces and all rasterizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trbr_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int RGB_BITS       = 24;

   // item kind codes
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // vertex slots in the vertex store
   localparam int VERT_COUNT = 6;
   localparam int V_AX = 0;
   localparam int V_AY = 1;
   localparam int V_BX = 2;
   localparam int V_BY = 3;
   localparam int V_CX = 4;
   localparam int V_CY = 5;

   // control flags of a position travelling down the pipeline
   typedef struct packed {
      logic active;
      logic last;
   } trbr_flags_type;

endpackage

`default_nettype wire

/* design/trbr_req_if.sv */
// ----------------------------------------------------------------------------
// trbr_req_if: request channel of the triangle rasterizer
// Valid/ready channel carrying the item kind, three vertices and a color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface trbr_req_if import trbr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] ax;
   logic signed [COORD_BITS-1:0] ay;
   logic signed [COORD_BITS-1:0] bx;
   logic signed [COORD_BITS-1:0] by;
   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic [RGB_BITS-1:0]          rgb;

   modport source (
      output valid, kind, ax, ay, bx, by, cx, cy, rgb,
      input  ready
   );

   modport sink (
      input  valid, kind, ax, ay, bx, by, cx, cy, rgb,
      output ready
   );

endinterface

`default_nettype wire

/* design/trbr_rsp_if.sv */
// ----------------------------------------------------------------------------
// trbr_rsp_if: response channel of the triangle rasterizer
// Valid/ready channel carrying one scanned pixel with coverage and color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface trbr_rsp_if import trbr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                         valid;
   logic                         ready;
   logic                         active;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;
   logic                         covered;
   logic                         final_res;
   logic [RGB_BITS-1:0]          pixel_rgb;

   modport source (
      output valid, active, px, py, covered, final_res, pixel_rgb,
      input  ready
   );

   modport sink (
      input  valid, active, px, py, covered, final_res, pixel_rgb,
      output ready
   );

endinterface

`default_nettype wire

/* design/triangle_bbox_rasterizer.sv */
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer: edge-function triangle rasterizer
// Scans the bounding box of a triangle and flags each covered pixel.
// ----------------------------------------------------------------------------
// A start item (kind 0) loads three signed vertices and a 24-bit color and
// returns the first bounding-box position (min x, min y); each step item
// (kind 1) returns the next position, y advancing fastest and wrapping to
// min y while x steps. Every item returns exactly one result item. A pixel is
// covered when the edge functions of all three sides are non-negative or all
// non-positive, so a degenerate triangle still covers its line. The last
// position (max x, max y) carries final_res and ends the scan; a step with no
// scan running returns active = 0 with all other fields zero. A start while
// a scan runs drops that scan. Throughput is one item per clock while rsp
// ready stays high: the block is a two-register pipeline (position register,
// then the edge evaluation with its six parallel multipliers feeding the
// result register), and an accepted item passes the position register and
// then the result register, which drives the response channel. The pipeline
// moves as a whole whenever the result register is empty or being taken, and
// req ready follows rsp ready in the same cycle when both registers are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_bbox_rasterizer import trbr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   trbr_req_if.sink   req_ch,
   trbr_rsp_if.source rsp_ch
);

   logic                         advance;     // pipeline moves this cycle
   logic                         load;        // request item accepted
   logic                         stage_valid;
   trbr_flags_type               stage_flags;
   logic signed [COORD_BITS-1:0] stage_x;
   logic signed [COORD_BITS-1:0] stage_y;
   logic signed [COORD_BITS-1:0] stage_vert [VERT_COUNT];
   logic [RGB_BITS-1:0]          stage_rgb;
   logic                         out_valid;

   // advance when the result register is empty or its item is taken
   assign advance      = !out_valid || rsp_ch.ready;
   // take a new item when the position register is empty or drains now
   assign req_ch.ready = !stage_valid || advance;
   assign load         = req_ch.valid && req_ch.ready;

   // scan sequencer and position register
   trbr_scan #(
      .COORD_BITS (COORD_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .advance     (advance),
      .kind        (req_ch.kind),
      .ax          (req_ch.ax),
      .ay          (req_ch.ay),
      .bx          (req_ch.bx),
      .by          (req_ch.by),
      .cx          (req_ch.cx),
      .cy          (req_ch.cy),
      .rgb         (req_ch.rgb),
      .stage_valid (stage_valid),
      .stage_flags (stage_flags),
      .stage_x     (stage_x),
      .stage_y     (stage_y),
      .stage_vert  (stage_vert),
      .stage_rgb   (stage_rgb)
   );

   // coverage test and result register
   trbr_cover #(
      .COORD_BITS (COORD_BITS)
   ) u_cover (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_flags (stage_flags),
      .stage_x     (stage_x),
      .stage_y     (stage_y),
      .stage_vert  (stage_vert),
      .stage_rgb   (stage_rgb),
      .out_valid   (out_valid),
      .out_active  (rsp_ch.active),
      .out_x       (rsp_ch.px),
      .out_y       (rsp_ch.py),
      .out_covered (rsp_ch.covered),
      .out_last    (rsp_ch.final_res),
      .out_rgb     (rsp_ch.pixel_rgb)
   );

   assign rsp_ch.valid = out_valid;

endmodule

`default_nettype wire

/* design/trbr_scan.sv */
// ----------------------------------------------------------------------------
// trbr_scan: bounding-box scan sequencer
// Holds the triangle, its bounding box and the scan position; on each accepted
// item picks the position to emit and loads it into the position stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trbr_scan import trbr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         advance,
   input  logic                         kind,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic [RGB_BITS-1:0]          rgb,
   output logic                         stage_valid,
   output trbr_flags_type               stage_flags,
   output logic signed [COORD_BITS-1:0] stage_x,
   output logic signed [COORD_BITS-1:0] stage_y,
   output logic signed [COORD_BITS-1:0] stage_vert [VERT_COUNT],
   output logic [RGB_BITS-1:0]          stage_rgb
);

   // triangle and scan state
   logic signed [COORD_BITS-1:0] vert_ff [VERT_COUNT];
   logic [RGB_BITS-1:0]          rgb_ff;
   logic signed [COORD_BITS-1:0] min_y_ff, min_y_in;
   logic signed [COORD_BITS-1:0] max_x_ff, max_x_in;
   logic signed [COORD_BITS-1:0] max_y_ff, max_y_in;
   logic signed [COORD_BITS-1:0] scan_x_ff, scan_x_in;
   logic signed [COORD_BITS-1:0] scan_y_ff, scan_y_in;
   logic                         scanning_ff, scanning_in;

   // position stage
   logic                         valid_ff;
   trbr_flags_type               flags_ff, flags_in;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic signed [COORD_BITS-1:0] vs_ff [VERT_COUNT];
   logic [RGB_BITS-1:0]          srgb_ff, srgb_in;

   logic signed [COORD_BITS-1:0] new_min_x, new_max_x, new_min_y, new_max_y;
   logic signed [COORD_BITS-1:0] lo_ab_x, hi_ab_x, lo_ab_y, hi_ab_y;
   logic                         y_wrap;
   logic                         is_start;

   assign is_start = (kind == KIND_START);

   // bounding box of the incoming triangle
   always_comb begin
      lo_ab_x   = (ax < bx) ? ax : bx;
      hi_ab_x   = (ax > bx) ? ax : bx;
      lo_ab_y   = (ay < by) ? ay : by;
      hi_ab_y   = (ay > by) ? ay : by;
      new_min_x = (lo_ab_x < cx) ? lo_ab_x : cx;
      new_max_x = (hi_ab_x > cx) ? hi_ab_x : cx;
      new_min_y = (lo_ab_y < cy) ? lo_ab_y : cy;
      new_max_y = (hi_ab_y > cy) ? hi_ab_y : cy;
   end

   assign y_wrap = !(scan_y_ff < max_y_ff);

   always_comb begin
      min_y_in    = min_y_ff;
      max_x_in    = max_x_ff;
      max_y_in    = max_y_ff;
      scan_x_in   = scan_x_ff;
      scan_y_in   = scan_y_ff;
      scanning_in = scanning_ff;
      flags_in    = '0;
      srgb_in     = '0;
      if (is_start) begin
         min_y_in  = new_min_y;
         max_x_in  = new_max_x;
         max_y_in  = new_max_y;
         scan_x_in = new_min_x;
         scan_y_in = new_min_y;
         srgb_in   = rgb;
         flags_in.active = 1'b1;
         flags_in.last   = (new_min_x == new_max_x) && (new_min_y == new_max_y);
         scanning_in     = !flags_in.last;
      end else if (scanning_ff) begin
         // column scan: y fastest; at max y wrap to min y and step x
         if (y_wrap) begin
            scan_y_in = min_y_ff;
            scan_x_in = scan_x_ff + COORD_BITS'(1);
         end else begin
            scan_y_in = scan_y_ff + COORD_BITS'(1);
         end
         srgb_in         = rgb_ff;
         flags_in.active = 1'b1;
         flags_in.last   = (scan_x_in == max_x_ff) && (scan_y_in == max_y_ff);
         scanning_in     = !flags_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_y_ff    <= '0;
         max_x_ff    <= '0;
         max_y_ff    <= '0;
         scan_x_ff   <= '0;
         scan_y_ff   <= '0;
         scanning_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (load) begin
            min_y_ff    <= min_y_in;
            max_x_ff    <= max_x_in;
            max_y_ff    <= max_y_in;
            scan_x_ff   <= scan_x_in;
            scan_y_ff   <= scan_y_in;
            scanning_ff <= scanning_in;
            valid_ff    <= 1'b1;
         end else if (advance) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // triangle store and position stage payload
   always_ff @(posedge clock) begin
      if (load) begin
         if (is_start) begin
            vert_ff[V_AX] <= ax;
            vert_ff[V_AY] <= ay;
            vert_ff[V_BX] <= bx;
            vert_ff[V_BY] <= by;
            vert_ff[V_CX] <= cx;
            vert_ff[V_CY] <= cy;
            rgb_ff        <= rgb;
            vs_ff[V_AX]   <= ax;
            vs_ff[V_AY]   <= ay;
            vs_ff[V_BX]   <= bx;
            vs_ff[V_BY]   <= by;
            vs_ff[V_CX]   <= cx;
            vs_ff[V_CY]   <= cy;
         end else begin
            vs_ff <= vert_ff;
         end
         flags_ff <= flags_in;
         srgb_ff  <= srgb_in;
         x_ff     <= flags_in.active ? scan_x_in : '0;
         y_ff     <= flags_in.active ? scan_y_in : '0;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_flags = flags_ff;
   assign stage_x     = x_ff;
   assign stage_y     = y_ff;
   assign stage_vert  = vs_ff;
   assign stage_rgb   = srgb_ff;

endmodule

`default_nettype wire

/* design/trbr_cover.sv */
// ----------------------------------------------------------------------------
// trbr_cover: edge-function coverage test and result register
// Evaluates the edge function of each triangle side at the staged position
// and registers the finished pixel for the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trbr_cover import trbr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         stage_valid,
   input  trbr_flags_type               stage_flags,
   input  logic signed [COORD_BITS-1:0] stage_x,
   input  logic signed [COORD_BITS-1:0] stage_y,
   input  logic signed [COORD_BITS-1:0] stage_vert [VERT_COUNT],
   input  logic [RGB_BITS-1:0]          stage_rgb,
   output logic                         out_valid,
   output logic                         out_active,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic                         out_covered,
   output logic                         out_last,
   output logic [RGB_BITS-1:0]          out_rgb
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int EDGE_BITS = PROD_BITS + 1;

   logic [2:0] non_neg;
   logic [2:0] non_pos;
   logic       in_tri;

   logic                         valid_ff;
   trbr_flags_type               flags_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic                         covered_ff, covered_in;
   logic [RGB_BITS-1:0]          rgb_ff;

   // edge k runs from vertex k to vertex k+1 (mod 3)
   for (genvar k = 0; k < 3; k++) begin : g_edge
      localparam int X0 = 2 * k;
      localparam int Y0 = 2 * k + 1;
      localparam int X1 = (2 * k + 2) % VERT_COUNT;
      localparam int Y1 = (2 * k + 3) % VERT_COUNT;

      logic signed [DIFF_BITS-1:0] ex, ey, px_d, py_d;
      logic signed [PROD_BITS-1:0] p_a, p_b;
      logic signed [EDGE_BITS-1:0] w;

      assign ex   = DIFF_BITS'(stage_vert[X1]) - DIFF_BITS'(stage_vert[X0]);
      assign ey   = DIFF_BITS'(stage_vert[Y1]) - DIFF_BITS'(stage_vert[Y0]);
      assign px_d = DIFF_BITS'(stage_x) - DIFF_BITS'(stage_vert[X0]);
      assign py_d = DIFF_BITS'(stage_y) - DIFF_BITS'(stage_vert[Y0]);
      assign p_a  = PROD_BITS'(ex) * PROD_BITS'(py_d);
      assign p_b  = PROD_BITS'(ey) * PROD_BITS'(px_d);
      assign w    = EDGE_BITS'(p_a) - EDGE_BITS'(p_b);

      assign non_neg[k] = !w[EDGE_BITS-1];
      assign non_pos[k] = w[EDGE_BITS-1] || (w == '0);
   end

   // both orientations count, so collinear triangles cover their segment
   assign in_tri     = (&non_neg) || (&non_pos);
   assign covered_in = stage_flags.active && in_tri;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_valid) begin
         flags_ff   <= stage_flags;
         x_ff       <= stage_x;
         y_ff       <= stage_y;
         covered_ff <= covered_in;
         rgb_ff     <= stage_rgb;
      end
   end

   assign out_valid   = valid_ff;
   assign out_active  = flags_ff.active;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_covered = covered_ff;
   assign out_last    = flags_ff.last;
   assign out_rgb     = rgb_ff;

endmodule

`default_nettype wire

/* bench/trbr_score_pkg.sv */
// ----------------------------------------------------------------------------
// trbr_score_pkg: pixel scoreboard for the triangle rasterizer bench
// Holds its own copy of the vertices, bounding box and scan position, works
// out the pixel item that each accepted request item must produce and
// compares the returned pixel items with those expectations in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trbr_score_pkg;
   import trbr_pkg::*;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_type;

   typedef struct packed {
      logic                kind;
      coord_type           ax, ay, bx, by, cx, cy;
      logic [RGB_BITS-1:0] rgb;
   } tri_item_type;

   typedef struct packed {
      logic                active;
      coord_type           px;
      coord_type           py;
      logic                covered;
      logic                final_res;
      logic [RGB_BITS-1:0] pixel_rgb;
   } pixel_item_type;

   class pixel_scoreboard;
      int                  verts[VERT_COUNT];
      int                  box_lo_y, box_hi_x, box_hi_y;
      int                  cur_x, cur_y;
      logic [RGB_BITS-1:0] fill;
      bit                  busy;
      pixel_item_type      due_pixels[$];
      int                  errors, starts, steps, idle_steps, checked, covered, finals;

      function new();
         foreach (verts[i]) verts[i] = 0;
         box_lo_y = 0; box_hi_x = 0; box_hi_y = 0;
         cur_x = 0; cur_y = 0;
         fill = '0;
         busy = 1'b0;
         errors = 0; starts = 0; steps = 0; idle_steps = 0;
         checked = 0; covered = 0; finals = 0;
      endfunction

      function longint edge_value(int x0, int y0, int x1, int y1, int x, int y);
         return longint'(x1 - x0) * (y - y0) - longint'(y1 - y0) * (x - x0);
      endfunction

      // evaluate the current scan position and queue the pixel it yields
      function void queue_pixel();
         longint         w0, w1, w2;
         pixel_item_type pix;
         w0 = edge_value(verts[V_AX], verts[V_AY], verts[V_BX], verts[V_BY], cur_x, cur_y);
         w1 = edge_value(verts[V_BX], verts[V_BY], verts[V_CX], verts[V_CY], cur_x, cur_y);
         w2 = edge_value(verts[V_CX], verts[V_CY], verts[V_AX], verts[V_AY], cur_x, cur_y);
         pix.active    = 1'b1;
         pix.px        = coord_type'(cur_x);
         pix.py        = coord_type'(cur_y);
         pix.covered   = (w0 >= 0 && w1 >= 0 && w2 >= 0) || (w0 <= 0 && w1 <= 0 && w2 <= 0);
         pix.final_res = (cur_x == box_hi_x) && (cur_y == box_hi_y);
         pix.pixel_rgb = fill;
         if (pix.final_res) busy = 1'b0;
         due_pixels.push_back(pix);
      endfunction

      function void note_item(tri_item_type it);
         int lo_x;
         if (it.kind == KIND_START) begin
            starts++;
            verts[V_AX] = $signed(it.ax);
            verts[V_AY] = $signed(it.ay);
            verts[V_BX] = $signed(it.bx);
            verts[V_BY] = $signed(it.by);
            verts[V_CX] = $signed(it.cx);
            verts[V_CY] = $signed(it.cy);
            fill     = it.rgb;
            lo_x     = verts[V_AX];
            box_hi_x = verts[V_AX];
            box_lo_y = verts[V_AY];
            box_hi_y = verts[V_AY];
            for (int i = V_BX; i <= V_CX; i += 2) begin
               if (verts[i] < lo_x) lo_x = verts[i];
               if (verts[i] > box_hi_x) box_hi_x = verts[i];
               if (verts[i+1] < box_lo_y) box_lo_y = verts[i+1];
               if (verts[i+1] > box_hi_y) box_hi_y = verts[i+1];
            end
            cur_x = lo_x;
            cur_y = box_lo_y;
            busy  = 1'b1;
            queue_pixel();
         end else begin
            steps++;
            if (!busy) begin
               idle_steps++;
               due_pixels.push_back('0);
            end else begin
               // y runs fastest, wrap to the box bottom and advance x
               if (cur_y < box_hi_y) begin
                  cur_y++;
               end else begin
                  cur_y = box_lo_y;
                  cur_x++;
               end
               queue_pixel();
            end
         end
      endfunction

      function void match(string name, logic signed [31:0] want, logic signed [31:0] got);
         if (got !== want) begin
            errors++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_pixel(pixel_item_type got);
         pixel_item_type want;
         if (due_pixels.size() == 0) begin
            errors++;
            $error("pixel item with none expected: px %0d py %0d", got.px, got.py);
            return;
         end
         want = due_pixels.pop_front();
         checked++;
         if (want.covered && want.active) covered++;
         if (want.final_res) finals++;
         match("active", want.active, got.active);
         match("px", want.px, got.px);
         match("py", want.py, got.py);
         match("covered", want.covered, got.covered);
         match("final_res", want.final_res, got.final_res);
         match("pixel_rgb", want.pixel_rgb, got.pixel_rgb);
      endfunction

      function int pending();
         return due_pixels.size();
      endfunction
   endclass

endpackage

`default_nettype wire

/* bench/triangle_bbox_rasterizer_tb.sv */
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer_tb: self-checking bench of the triangle rasterizer
// Drives start and step items with random gaps on the request side and random
// stalls on the response side, predicts every pixel item in a scoreboard and
// checks each returned pixel item field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_bbox_rasterizer_tb;
   import trbr_pkg::*;
   import trbr_score_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 21;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   sent = 0;
   bit   calm = 1'b0;   // set during the long stretch with no gaps or stalls

   pixel_scoreboard sb = new();

   trbr_req_if #(.COORD_BITS(COORD_BITS_DEF)) req_ch ();
   trbr_rsp_if #(.COORD_BITS(COORD_BITS_DEF)) rsp_ch ();

   triangle_bbox_rasterizer #(.COORD_BITS(COORD_BITS_DEF)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watch both channels. Values read here are the ones settled before the
   // edge, so an item counts exactly when valid and ready were both high.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_item('{req_ch.kind, req_ch.ax, req_ch.ay, req_ch.bx, req_ch.by,
                           req_ch.cx, req_ch.cy, req_ch.rgb});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_pixel('{rsp_ch.active, rsp_ch.px, rsp_ch.py, rsp_ch.covered,
                             rsp_ch.final_res, rsp_ch.pixel_rgb});
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: stall at random, except during the calm stretch.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !reset && (calm || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // Present one item and hold it until the block takes it. Gaps go in front
   // of the item, so valid never drops and rises within one time step.
   task automatic send_item(tri_item_type it);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= it.kind;
      req_ch.ax    <= it.ax;
      req_ch.ay    <= it.ay;
      req_ch.bx    <= it.bx;
      req_ch.by    <= it.by;
      req_ch.cx    <= it.cx;
      req_ch.cy    <= it.cy;
      req_ch.rgb   <= it.rgb;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic start_tri(int ax, int ay, int bx, int by, int cx, int cy,
                            logic [RGB_BITS-1:0] rgb);
      send_item('{KIND_START, coord_type'(ax), coord_type'(ay), coord_type'(bx),
                  coord_type'(by), coord_type'(cx), coord_type'(cy), rgb});
   endtask

   // Advance the scan; the vertex and color fields carry noise the block ignores.
   task automatic step_scan(int count);
      tri_item_type it;
      logic [127:0] noise;
      for (int i = 0; i < count; i++) begin
         noise   = {$urandom, $urandom, $urandom, $urandom};
         it      = noise[$bits(tri_item_type)-1:0];
         it.kind = KIND_STEP;
         send_item(it);
      end
   endtask

   function automatic int span(int a, int b, int c);
      int lo, hi;
      lo = a; hi = a;
      if (b < lo) lo = b;
      if (b > hi) hi = b;
      if (c < lo) lo = c;
      if (c > hi) hi = c;
      return hi - lo + 1;
   endfunction

   initial begin
      int v[VERT_COUNT];
      int base_x, base_y, wid_x, wid_y, full, count;
      int pick;

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_START;
      req_ch.ax    <= '0;
      req_ch.ay    <= '0;
      req_ch.bx    <= '0;
      req_ch.by    <= '0;
      req_ch.cx    <= '0;
      req_ch.cy    <= '0;
      req_ch.rgb   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // step on an idle block: inactive, all fields zero
      step_scan(1);
      // single-pixel box: last mark on the start item, then idle again
      start_tri(0, 0, 0, 0, 0, 0, 24'h000000);
      step_scan(1);
      // full-range box, far too large to finish; drop it with a new start
      start_tri(-2048, -2048, 2047, -2048, -2048, 2047, 24'hFFFFFF);
      step_scan(2);
      // box pinned against the top corner, scanned to its last position
      start_tri(2045, 2047, 2047, 2045, 2047, 2047, 24'hA5C3E1);
      step_scan(8);
      // collinear vertices near the bottom corner: coverage along the segment
      start_tri(-2048, -2047, -2046, -2045, -2047, -2046, 24'h5A3C1E);
      step_scan(8);

      // Random part: mostly small triangles scanned to the end, some cut
      // short by a new start, some huge boxes and loose step noise.
      while (sent < RANDOM_ITEMS) begin
         calm = (sent >= 500 && sent < 750);
         pick = $urandom_range(99);
         if (pick < 75) begin
            base_x = $urandom_range(4088) - 2048;
            base_y = $urandom_range(4088) - 2048;
            wid_x  = $urandom_range(5);
            wid_y  = $urandom_range(5);
            for (int i = 0; i < VERT_COUNT; i += 2) begin
               v[i]   = base_x + $urandom_range(wid_x);
               v[i+1] = base_y + $urandom_range(wid_y);
            end
            // squash some triangles onto a line
            if ($urandom_range(4) == 0) begin
               case ($urandom_range(2))
                  0: begin
                     v[V_CX] = v[V_AX];
                     v[V_CY] = v[V_AY];
                  end
                  1: begin
                     v[V_BY] = v[V_AY];
                     v[V_CY] = v[V_AY];
                  end
                  default: begin
                     v[V_BX] = v[V_AX];
                     v[V_CX] = v[V_AX];
                  end
               endcase
            end
            full = span(v[V_AX], v[V_BX], v[V_CX]) * span(v[V_AY], v[V_BY], v[V_CY]) - 1;
            if ($urandom_range(99) < 15) count = $urandom_range(full);
            else if ($urandom_range(99) < 20) count = full + $urandom_range(2, 1);
            else count = full;
            start_tri(v[V_AX], v[V_AY], v[V_BX], v[V_BY], v[V_CX], v[V_CY],
                      RGB_BITS'($urandom_range(24'hFFFFFF)));
            step_scan(count);
         end else if (pick < 90) begin
            start_tri($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                      $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                      $urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
                      RGB_BITS'($urandom_range(24'hFFFFFF)));
            step_scan($urandom_range(4));
         end else begin
            step_scan($urandom_range(3, 1));
         end
      end
      calm = 1'b0;

      // drain: hold valid low and wait for every expected pixel item
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d start items, %0d step items (%0d on an idle block), %0d checked",
               sb.starts, sb.steps, sb.idle_steps, sb.checked);
      $display("Run: %0d covered pixels, %0d scans reached their last position",
               sb.covered, sb.finals);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
design/trbr_pkg.sv
design/trbr_req_if.sv
design/trbr_rsp_if.sv
design/trbr_scan.sv
design/trbr_cover.sv
design/triangle_bbox_rasterizer.sv
bench/trbr_score_pkg.sv
bench/triangle_bbox_rasterizer_tb.sv
